// ===== rtl/core/fdfb_pkg.sv =====
// ----------------------------------------------------------------------------
// fdfb_pkg
// shared constants, types and fixed-point helpers of the boundary node corrector
// ----------------------------------------------------------------------------
package fdfb_pkg;

   localparam int NODES     = 4096;
   localparam int BRANCHES  = 12;
   localparam int MATERIALS = 16;

   localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int BR_DEPTH = NODES * BRANCHES;
   localparam int BR_AW    = (BR_DEPTH > 1) ? $clog2(BR_DEPTH) : 1;
   localparam int CF_DEPTH = MATERIALS * BRANCHES;
   localparam int CF_AW    = (CF_DEPTH > 1) ? $clog2(CF_DEPTH) : 1;
   localparam int MAT_AW   = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
   localparam int BCNT_W   = $clog2(BRANCHES + 1);
   localparam int CLR_DEPTH = (BR_DEPTH > CF_DEPTH) ? BR_DEPTH : CF_DEPTH;
   localparam int CLR_W    = $clog2(CLR_DEPTH + 1);

   localparam int DIV_STEPS = 56;
   localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

   localparam logic signed [31:0] Q_ONE   = 32'sh0100_0000;
   localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

   localparam logic ACT_PROCESS = 1'b0;
   localparam logic ACT_WRITE   = 1'b1;

   localparam logic [2:0] SEL_ADMIT = 3'd0;
   localparam logic [2:0] SEL_COUNT = 3'd1;
   localparam logic [2:0] SEL_B     = 3'd2;
   localparam logic [2:0] SEL_BD    = 3'd3;
   localparam logic [2:0] SEL_BDH   = 3'd4;
   localparam logic [2:0] SEL_BFH   = 3'd5;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_M_LOSS, ST_W_LOSS, ST_M_BETA, ST_W_BETA, ST_M_LKB, ST_W_LKB,
      ST_DIV_FAC, ST_WAIT_FAC, ST_WAIT_U0,
      ST_B1_RD, ST_B1_BDH, ST_B1_BFH, ST_B1_DBL, ST_B1_SUB, ST_B1_FAC,
      ST_B1_WAIT, ST_B1_ACC, ST_DU,
      ST_B2_RD, ST_B2_B, ST_B2_BD, ST_B2_BFH, ST_B2_ACC, ST_B2_VN, ST_B2_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic signed [31:0] quot;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'(Q_MAX)) return Q_MAX;
      if (x < 64'(Q_MIN)) return Q_MIN;
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd8388608;
      return sat32(t >>> 24);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(64'(a) + 64'(b));
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(64'(a) - 64'(b));
   endfunction

   function automatic logic signed [31:0] qdbl(input logic signed [31:0] a);
      return sat32(64'(a) + 64'(a));
   endfunction

endpackage

// ===== rtl/core/fdfb_req_if.sv =====
// ----------------------------------------------------------------------------
// fdfb_req_if
// request channel: process and table-write transactions
// ----------------------------------------------------------------------------
interface fdfb_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [11:0]        node;
   logic signed [31:0] pressure_in;
   logic [30:0]        area_factor;
   logic [3:0]         material;
   logic [3:0]         branch;
   logic [2:0]         coef_select;
   logic signed [31:0] coef_value;

   modport source (output valid, action, node, pressure_in, area_factor, material,
                   branch, coef_select, coef_value, input ready);
   modport sink   (input valid, action, node, pressure_in, area_factor, material,
                   branch, coef_select, coef_value, output ready);
endinterface

// ===== rtl/core/fdfb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdfb_rsp_if
// response channel: corrected node pressure
// ----------------------------------------------------------------------------
interface fdfb_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        node_out;
   logic signed [31:0] pressure_out;

   modport source (output valid, node_out, pressure_out, input ready);
   modport sink   (input valid, node_out, pressure_out, output ready);
endinterface

// ===== rtl/core/fdfb_div.sv =====
// ----------------------------------------------------------------------------
// fdfb_div
// bit-serial saturating q8.24 divider, rounds half away from zero
// ----------------------------------------------------------------------------
module fdfb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fdfb_pkg::div_req_type req,
   output fdfb_pkg::div_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [fdfb_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic [55:0]                work_ff, work_in;
   logic [31:0]                rem_ff, rem_in;
   logic [31:0]                ud_ff, ud_in;
   logic                       neg_ff, neg_in;
   logic signed [31:0]         quot_ff, quot_in;

   logic signed [32:0] nx, dx;
   logic [32:0]        n_abs, d_abs, trial;
   logic               ge;

   always_comb begin
      nx    = 33'(req.num);
      dx    = 33'(req.den);
      n_abs = nx[32] ? 33'(-nx) : 33'(nx);
      d_abs = dx[32] ? 33'(-dx) : 33'(dx);
      trial = {rem_ff, work_ff[55]};
      ge    = trial >= {1'b0, ud_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in  = ge ? 32'(trial - {1'b0, ud_ff}) : trial[31:0];
            work_in = {work_ff[54:0], ge};
            cnt_in  = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               quot_in = (work_ff >= 56'h7fff_ffff) ? fdfb_pkg::Q_MAX : work_ff[31:0];
            end else begin
               quot_in = (work_ff >= 56'h8000_0000) ? fdfb_pkg::Q_MIN
                                                   : 32'(-work_ff[31:0]);
            end
         end
      end else if (req.start) begin
         if (req.den == '0) begin
            done_in = 1'b1;
            quot_in = req.num[31] ? fdfb_pkg::Q_MIN : fdfb_pkg::Q_MAX;
         end else begin
            busy_in = 1'b1;
            cnt_in  = fdfb_pkg::DIV_CW'(fdfb_pkg::DIV_STEPS);
            work_in = {n_abs[31:0], 24'd0} + 56'(d_abs[31:1]);
            rem_in  = '0;
            ud_in   = d_abs[31:0];
            neg_in  = req.num[31] ^ req.den[31];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ===== rtl/core/fdtd_freq_dep_boundary_node_top.sv =====
// ----------------------------------------------------------------------------
// fdtd_freq_dep_boundary_node_top
// frequency-dependent rlc boundary node corrector, one node per transaction
// ----------------------------------------------------------------------------
// process: two 56-step serial divisions and the shared multiplier, then each of the
//    two branch loops makes one pass per branch of the material's branch count
// ordering: one transaction at a time; a table write is taken only while idle
// reset: a clearing pass over NODES*BRANCHES (49152) addresses zeroes the history,
//    branch and coefficient memories; no request is taken meanwhile, csr writes are
module fdtd_freq_dep_boundary_node_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata,
   fdfb_req_if.sink    req_ch,
   fdfb_rsp_if.source  rsp_ch
);

   fdfb_pkg::state_type state_ff, state_in;

   logic [30:0]                   loss_ff;
   logic [fdfb_pkg::CLR_W-1:0]    clr_ff;
   logic signed [31:0]            adm_ff [fdfb_pkg::MATERIALS];
   logic [fdfb_pkg::BCNT_W-1:0]   cnt_ff [fdfb_pkg::MATERIALS];

   logic [63:0] hist_mem [fdfb_pkg::NODES];
   logic [63:0] br_mem   [fdfb_pkg::BR_DEPTH];
   logic signed [31:0] cb_mem   [fdfb_pkg::CF_DEPTH];
   logic signed [31:0] cbd_mem  [fdfb_pkg::CF_DEPTH];
   logic signed [31:0] cbdh_mem [fdfb_pkg::CF_DEPTH];
   logic signed [31:0] cbfh_mem [fdfb_pkg::CF_DEPTH];

   logic [63:0]        hist_rd_ff, br_rd_ff;
   logic signed [31:0] cb_ff, cbd_ff, cbdh_ff, cbfh_ff;

   logic [11:0]                 node_ff;
   logic [fdfb_pkg::BR_AW-1:0]  nbase_ff;
   logic [fdfb_pkg::CF_AW-1:0]  mbase_ff;
   logic signed [31:0]          u0_ff, ssaf_ff, beta_ff;
   logic [fdfb_pkg::BCNT_W-1:0] nbr_ff, m_ff;
   logic signed [31:0]          a_ff, lkb_ff, den_ff, t_ff, t1_ff, fac_ff, du_ff;
   logic signed [31:0]          acc_ff, vn_ff;
   logic signed [63:0]          prod_ff;
   logic signed [31:0]          rnd_ff;

   logic               rsp_valid_ff;
   logic [11:0]        rsp_node_ff;
   logic signed [31:0] rsp_press_ff;

   fdfb_pkg::div_req_type div_req;
   fdfb_pkg::div_rsp_type div_rsp;

   logic               accept, is_proc, is_wr, node_ok, mat_ok, br_ok, clear_last;
   logic               rsp_load, br_re, br_we;
   logic signed [31:0] mul_a, mul_b;
   logic [fdfb_pkg::MAT_AW-1:0] mat_idx;
   logic [fdfb_pkg::CF_AW-1:0]  cf_wa, cf_ra;
   logic [fdfb_pkg::BR_AW-1:0]  br_addr;
   logic signed [31:0] u2, v_old, g_old, g_new;
   logic signed [32:0] vsum;
   logic signed [31:0] cnt_clamp;
   logic               m_last;

   assign u2    = hist_rd_ff[31:0];
   assign v_old = br_rd_ff[63:32];
   assign g_old = br_rd_ff[31:0];

   assign accept  = req_ch.valid && req_ch.ready;
   assign is_proc = accept && (req_ch.action == fdfb_pkg::ACT_PROCESS);
   assign is_wr   = accept && (req_ch.action == fdfb_pkg::ACT_WRITE);
   assign node_ok = 32'(req_ch.node) < fdfb_pkg::NODES;
   assign mat_ok  = 32'(req_ch.material) < fdfb_pkg::MATERIALS;
   assign br_ok   = 32'(req_ch.branch) < fdfb_pkg::BRANCHES;
   assign mat_idx = fdfb_pkg::MAT_AW'(req_ch.material);
   assign cf_wa   = fdfb_pkg::CF_AW'(int'(req_ch.material) * fdfb_pkg::BRANCHES
                                     + int'(req_ch.branch));
   assign cf_ra   = fdfb_pkg::CF_AW'(mbase_ff + fdfb_pkg::CF_AW'(m_ff));
   assign br_addr = fdfb_pkg::BR_AW'(nbase_ff + fdfb_pkg::BR_AW'(m_ff));
   assign m_last  = (m_ff + 1'b1) == nbr_ff;
   assign clear_last = clr_ff == fdfb_pkg::CLR_W'(fdfb_pkg::CLR_DEPTH - 1);
   assign vsum    = (33'(vn_ff) + 33'(v_old)) >>> 1;
   assign g_new   = fdfb_pkg::qadd(g_old, vsum[31:0]);
   assign cnt_clamp = req_ch.coef_value;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdfb_pkg::ST_CLEAR:    if (clear_last) state_in = fdfb_pkg::ST_IDLE;
         fdfb_pkg::ST_IDLE:     if (is_proc && node_ok) state_in = fdfb_pkg::ST_M_LOSS;
         fdfb_pkg::ST_M_LOSS:   state_in = fdfb_pkg::ST_W_LOSS;
         fdfb_pkg::ST_W_LOSS:   state_in = fdfb_pkg::ST_M_BETA;
         fdfb_pkg::ST_M_BETA:   state_in = fdfb_pkg::ST_W_BETA;
         fdfb_pkg::ST_W_BETA:   state_in = fdfb_pkg::ST_M_LKB;
         fdfb_pkg::ST_M_LKB:    state_in = fdfb_pkg::ST_W_LKB;
         fdfb_pkg::ST_W_LKB:    state_in = fdfb_pkg::ST_DIV_FAC;
         fdfb_pkg::ST_DIV_FAC:  state_in = fdfb_pkg::ST_WAIT_FAC;
         fdfb_pkg::ST_WAIT_FAC: if (div_rsp.done) state_in = fdfb_pkg::ST_WAIT_U0;
         fdfb_pkg::ST_WAIT_U0: begin
            if (div_rsp.done) begin
               state_in = (nbr_ff == '0) ? fdfb_pkg::ST_DU : fdfb_pkg::ST_B1_RD;
            end
         end
         fdfb_pkg::ST_B1_RD:    state_in = fdfb_pkg::ST_B1_BDH;
         fdfb_pkg::ST_B1_BDH:   state_in = fdfb_pkg::ST_B1_BFH;
         fdfb_pkg::ST_B1_BFH:   state_in = fdfb_pkg::ST_B1_DBL;
         fdfb_pkg::ST_B1_DBL:   state_in = fdfb_pkg::ST_B1_SUB;
         fdfb_pkg::ST_B1_SUB:   state_in = fdfb_pkg::ST_B1_FAC;
         fdfb_pkg::ST_B1_FAC:   state_in = fdfb_pkg::ST_B1_WAIT;
         fdfb_pkg::ST_B1_WAIT:  state_in = fdfb_pkg::ST_B1_ACC;
         fdfb_pkg::ST_B1_ACC:   state_in = m_last ? fdfb_pkg::ST_DU : fdfb_pkg::ST_B1_RD;
         fdfb_pkg::ST_DU:       state_in = (nbr_ff == '0) ? fdfb_pkg::ST_OUT
                                                          : fdfb_pkg::ST_B2_RD;
         fdfb_pkg::ST_B2_RD:    state_in = fdfb_pkg::ST_B2_B;
         fdfb_pkg::ST_B2_B:     state_in = fdfb_pkg::ST_B2_BD;
         fdfb_pkg::ST_B2_BD:    state_in = fdfb_pkg::ST_B2_BFH;
         fdfb_pkg::ST_B2_BFH:   state_in = fdfb_pkg::ST_B2_ACC;
         fdfb_pkg::ST_B2_ACC:   state_in = fdfb_pkg::ST_B2_VN;
         fdfb_pkg::ST_B2_VN:    state_in = fdfb_pkg::ST_B2_WR;
         fdfb_pkg::ST_B2_WR:    state_in = m_last ? fdfb_pkg::ST_OUT : fdfb_pkg::ST_B2_RD;
         fdfb_pkg::ST_OUT:      if (rsp_load) state_in = fdfb_pkg::ST_IDLE;
         default:               state_in = fdfb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready  = 1'b0;
      rsp_load      = 1'b0;
      br_re         = 1'b0;
      br_we         = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_req.start = 1'b0;
      div_req.num   = fdfb_pkg::qdbl(a_ff);
      div_req.den   = fdfb_pkg::qadd(fdfb_pkg::Q_ONE, lkb_ff);
      case (state_ff)
         fdfb_pkg::ST_IDLE:    req_ch.ready = 1'b1;
         fdfb_pkg::ST_M_LOSS: begin
            mul_a = {1'b0, loss_ff};
            mul_b = ssaf_ff;
         end
         fdfb_pkg::ST_M_BETA: begin
            mul_a = rnd_ff;
            mul_b = beta_ff;
         end
         fdfb_pkg::ST_M_LKB: begin
            mul_a = rnd_ff;
            mul_b = u2;
         end
         fdfb_pkg::ST_DIV_FAC: div_req.start = 1'b1;
         fdfb_pkg::ST_WAIT_FAC: begin
            div_req.start = div_rsp.done;
            div_req.num   = fdfb_pkg::qadd(u0_ff, t_ff);
            div_req.den   = den_ff;
         end
         fdfb_pkg::ST_B1_RD:   br_re = 1'b1;
         fdfb_pkg::ST_B1_BDH: begin
            mul_a = cbdh_ff;
            mul_b = v_old;
         end
         fdfb_pkg::ST_B1_BFH: begin
            mul_a = cbfh_ff;
            mul_b = g_old;
         end
         fdfb_pkg::ST_B1_FAC: begin
            mul_a = fac_ff;
            mul_b = t_ff;
         end
         fdfb_pkg::ST_B2_RD:   br_re = 1'b1;
         fdfb_pkg::ST_B2_B: begin
            mul_a = cb_ff;
            mul_b = du_ff;
         end
         fdfb_pkg::ST_B2_BD: begin
            mul_a = cbd_ff;
            mul_b = v_old;
         end
         fdfb_pkg::ST_B2_BFH: begin
            mul_a = cbfh_ff;
            mul_b = g_old;
         end
         fdfb_pkg::ST_B2_WR:   br_we = 1'b1;
         fdfb_pkg::ST_OUT:     rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   fdfb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // control state and small tables
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdfb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         loss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < fdfb_pkg::MATERIALS; i++) begin
            adm_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == fdfb_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) loss_ff <= csr_wdata;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (is_wr && mat_ok) begin
            if (req_ch.coef_select == fdfb_pkg::SEL_ADMIT) adm_ff[mat_idx] <= req_ch.coef_value;
            if (req_ch.coef_select == fdfb_pkg::SEL_COUNT) begin
               if (cnt_clamp < 0) begin
                  cnt_ff[mat_idx] <= '0;
               end else if (cnt_clamp > fdfb_pkg::BRANCHES) begin
                  cnt_ff[mat_idx] <= fdfb_pkg::BCNT_W'(fdfb_pkg::BRANCHES);
               end else begin
                  cnt_ff[mat_idx] <= fdfb_pkg::BCNT_W'(cnt_clamp);
               end
            end
         end
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (state_ff == fdfb_pkg::ST_CLEAR) begin
         if (32'(clr_ff) < fdfb_pkg::NODES) hist_mem[fdfb_pkg::NODE_AW'(clr_ff)] <= '0;
      end else if (rsp_load) begin
         hist_mem[fdfb_pkg::NODE_AW'(node_ff)] <= {u0_ff, hist_rd_ff[63:32]};
      end
      if (is_proc) hist_rd_ff <= hist_mem[fdfb_pkg::NODE_AW'(req_ch.node)];
   end

   // branch state memory
   always_ff @(posedge clock) begin
      if (state_ff == fdfb_pkg::ST_CLEAR) begin
         if (32'(clr_ff) < fdfb_pkg::BR_DEPTH) br_mem[fdfb_pkg::BR_AW'(clr_ff)] <= '0;
      end else if (br_we) begin
         br_mem[br_addr] <= {vn_ff, g_new};
      end
      if (br_re) br_rd_ff <= br_mem[br_addr];
   end

   // coefficient memories
   always_ff @(posedge clock) begin
      if (state_ff == fdfb_pkg::ST_CLEAR) begin
         if (32'(clr_ff) < fdfb_pkg::CF_DEPTH) begin
            cb_mem[fdfb_pkg::CF_AW'(clr_ff)]   <= '0;
            cbd_mem[fdfb_pkg::CF_AW'(clr_ff)]  <= '0;
            cbdh_mem[fdfb_pkg::CF_AW'(clr_ff)] <= '0;
            cbfh_mem[fdfb_pkg::CF_AW'(clr_ff)] <= '0;
         end
      end else if (is_wr && mat_ok && br_ok) begin
         if (req_ch.coef_select == fdfb_pkg::SEL_B)   cb_mem[cf_wa]   <= req_ch.coef_value;
         if (req_ch.coef_select == fdfb_pkg::SEL_BD)  cbd_mem[cf_wa]  <= req_ch.coef_value;
         if (req_ch.coef_select == fdfb_pkg::SEL_BDH) cbdh_mem[cf_wa] <= req_ch.coef_value;
         if (req_ch.coef_select == fdfb_pkg::SEL_BFH) cbfh_mem[cf_wa] <= req_ch.coef_value;
      end
      if (br_re) begin
         cb_ff   <= cb_mem[cf_ra];
         cbd_ff  <= cbd_mem[cf_ra];
         cbdh_ff <= cbdh_mem[cf_ra];
         cbfh_ff <= cbfh_mem[cf_ra];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      rnd_ff  <= fdfb_pkg::qround(prod_ff);
      if (is_proc) begin
         node_ff  <= req_ch.node;
         nbase_ff <= fdfb_pkg::BR_AW'(int'(req_ch.node) * fdfb_pkg::BRANCHES);
         mbase_ff <= fdfb_pkg::CF_AW'(int'(mat_idx) * fdfb_pkg::BRANCHES);
         u0_ff    <= req_ch.pressure_in;
         ssaf_ff  <= {1'b0, req_ch.area_factor};
         beta_ff  <= mat_ok ? adm_ff[mat_idx] : '0;
         nbr_ff   <= mat_ok ? cnt_ff[mat_idx] : '0;
      end
      case (state_ff)
         fdfb_pkg::ST_M_BETA:   a_ff   <= rnd_ff;
         fdfb_pkg::ST_M_LKB:    lkb_ff <= rnd_ff;
         fdfb_pkg::ST_DIV_FAC: begin
            t_ff   <= rnd_ff;
            den_ff <= fdfb_pkg::qadd(fdfb_pkg::Q_ONE, lkb_ff);
         end
         fdfb_pkg::ST_WAIT_FAC: if (div_rsp.done) fac_ff <= div_rsp.quot;
         fdfb_pkg::ST_WAIT_U0: begin
            if (div_rsp.done) begin
               u0_ff <= div_rsp.quot;
               m_ff  <= '0;
            end
         end
         fdfb_pkg::ST_B1_DBL:   t1_ff <= fdfb_pkg::qdbl(rnd_ff);
         fdfb_pkg::ST_B1_SUB:   t_ff  <= fdfb_pkg::qsub(t1_ff, rnd_ff);
         fdfb_pkg::ST_B1_ACC: begin
            u0_ff <= fdfb_pkg::qsub(u0_ff, rnd_ff);
            m_ff  <= m_ff + 1'b1;
         end
         fdfb_pkg::ST_DU: begin
            du_ff <= fdfb_pkg::qsub(u0_ff, u2);
            m_ff  <= '0;
         end
         fdfb_pkg::ST_B2_BFH:   acc_ff <= rnd_ff;
         fdfb_pkg::ST_B2_ACC:   acc_ff <= fdfb_pkg::qadd(acc_ff, rnd_ff);
         fdfb_pkg::ST_B2_VN:    vn_ff  <= fdfb_pkg::qsub(acc_ff, fdfb_pkg::qdbl(rnd_ff));
         fdfb_pkg::ST_B2_WR:    m_ff   <= m_ff + 1'b1;
         default: ;
      endcase
      if (rsp_load) begin
         rsp_node_ff  <= node_ff;
         rsp_press_ff <= u0_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.node_out     = rsp_node_ff;
   assign rsp_ch.pressure_out = rsp_press_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdfb_pkg::ST_CLEAR) |-> !req_ch.ready)
      else $error("request taken during clearing pass");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_branch_bound: assert property (@(posedge clock) disable iff (reset)
      (br_re || br_we) |-> (m_ff < nbr_ff))
      else $error("branch index beyond branch count");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("pending response overwritten");

endmodule
